// ----- hdl/fra_pkg.sv -----
// Package for the fraction arithmetic block: command codes, field widths and
// the sizes of the iterative gcd and divide datapath. No dependencies.
package fra_pkg;

    // Operation codes of the command field
    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    // Field widths
    localparam int IN_W   = 16;
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 32;

    // Magnitudes of the raw result fit in 32 unsigned bits
    localparam int MAG_W  = 32;
    localparam int CNT_W  = $clog2(MAG_W + 1);
    localparam int SHF_W  = $clog2(MAG_W);

endpackage

// ----- hdl/fra_if.sv -----
// Valid/ready stream interfaces for the fraction arithmetic block.
// Depends on fra_pkg for the command type and field widths.
interface fra_in_if;
    logic                                  valid;
    logic                                  ready;
    fra_pkg::t_cmd                         command;
    logic signed [fra_pkg::IN_W-1:0]       num_a;
    logic signed [fra_pkg::IN_W-1:0]       den_a;
    logic signed [fra_pkg::IN_W-1:0]       num_b;
    logic signed [fra_pkg::IN_W-1:0]       den_b;

    modport source (output valid, command, num_a, den_a, num_b, den_b, input ready);
    modport sink   (input valid, command, num_a, den_a, num_b, den_b, output ready);
endinterface

interface fra_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fra_pkg::NUM_W-1:0]      num_out;
    logic signed [fra_pkg::DEN_W-1:0]      den_out;

    modport source (output valid, num_out, den_out, input ready);
    modport sink   (input valid, num_out, den_out, output ready);
endinterface

// ----- hdl/fraction_arith_reduce.sv -----
// Fraction add/subtract/multiply/divide with gcd reduction of the result.
// Depends on fra_pkg and the stream interfaces in fra_if.sv.
//
//  Channel  Dir  Payload                                  Transaction when
//  i_in     in   command, num_a, den_a, num_b, den_b      valid && ready
//  o_out    out  num_out, den_out                         valid && ready
//
// A transaction runs through MUL (three products), SUM and PREP; a nonzero raw
// numerator goes on to GCD (binary gcd) and, with a gcd above one, to DIVN and
// DIVD (restoring divisions of |n| and |d| by the gcd), and FIN loads the output
// register. Products use one 16x16 multiplier, gcd steps and trial subtracts one
// 34-bit subtractor. i_in.ready is high only in the idle state; a finished
// result waits in the output register while the next transaction is accepted.
// Reset is synchronous, active low, and clears the sequencer and output valid.
module fraction_arith_reduce (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fra_in_if.sink        i_in,
    fra_out_if.source     o_out
);

    localparam int MW = fra_pkg::MAG_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_PREP,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_FIN
    } t_state;

    t_state                              r_state;
    fra_pkg::t_cmd                       r_cmd;
    logic signed [fra_pkg::IN_W-1:0]     r_na, r_da, r_nb, r_db;
    logic signed [31:0]                  r_t1, r_t2;
    logic signed [fra_pkg::NUM_W-1:0]    r_n;
    logic signed [fra_pkg::DEN_W-1:0]    r_d;
    logic [MW-1:0]                       r_u, r_v, r_g;
    logic [fra_pkg::SHF_W-1:0]           r_k;
    logic [fra_pkg::CNT_W-1:0]           r_cnt;
    logic                                r_out_valid;
    logic signed [fra_pkg::NUM_W-1:0]    r_num_out;
    logic signed [fra_pkg::DEN_W-1:0]    r_den_out;

    // Shared multiplier operands per product step
    logic signed [fra_pkg::IN_W-1:0]     mul_a, mul_b;
    logic signed [31:0]                  prod;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                mul_a = r_na;
                mul_b = (r_cmd == fra_pkg::CMD_MUL) ? r_nb : r_db;
            end
            2'd1: begin
                mul_a = r_nb;
                mul_b = r_da;
            end
            default: begin
                mul_a = r_da;
                mul_b = (r_cmd == fra_pkg::CMD_DIV) ? r_nb : r_db;
            end
        endcase
    end

    assign prod = 32'(mul_a) * 32'(mul_b);

    // Combine the cross products into the raw numerator
    logic signed [fra_pkg::NUM_W-1:0]    t1x, t2x, raw_n;

    assign t1x = 33'(r_t1);
    assign t2x = 33'(r_t2);

    always_comb begin
        case (r_cmd)
            fra_pkg::CMD_ADD: raw_n = t1x + t2x;
            fra_pkg::CMD_SUB: raw_n = t1x - t2x;
            default:          raw_n = t1x;
        endcase
    end

    // Magnitudes of the current numerator and denominator
    logic [MW-1:0]                       mag_n, mag_d;
    logic [fra_pkg::NUM_W-1:0]           neg_n;
    logic [fra_pkg::DEN_W-1:0]           neg_d;

    assign neg_n = -r_n;
    assign neg_d = -r_d;
    assign mag_n = r_n[fra_pkg::NUM_W-1] ? neg_n[MW-1:0] : r_n[MW-1:0];
    assign mag_d = r_d[fra_pkg::DEN_W-1] ? neg_d[MW-1:0] : r_d[MW-1:0];

    // Shared subtractor: gcd compare/subtract or division trial subtract
    logic [MW:0]                         op_a, op_b;
    logic [MW+1:0]                       sub_res;
    logic                                sub_neg;
    logic [MW-1:0]                       sub_flip;

    always_comb begin
        if (r_state == ST_GCD) begin
            op_a = {1'b0, r_u};
            op_b = {1'b0, r_v};
        end else begin
            op_a = {r_v, r_u[MW-1]};
            op_b = {1'b0, r_g};
        end
    end

    assign sub_res  = {1'b0, op_a} - {1'b0, op_b};
    assign sub_neg  = sub_res[MW+1];
    assign sub_flip = -sub_res[MW-1:0];

    // Gcd once either operand reaches zero, and the next quotient bit state
    logic [MW-1:0]                       gcd_val;
    logic                                gcd_done;
    logic [MW-1:0]                       quo;
    logic [fra_pkg::NUM_W-1:0]           quo_n;
    logic [fra_pkg::DEN_W-1:0]           quo_d;
    logic                                div_last;

    assign gcd_val  = (r_u | r_v) << r_k;
    assign gcd_done = (r_u == '0) || (r_v == '0);
    assign quo      = {r_u[MW-2:0], ~sub_neg};
    assign quo_n    = {1'b0, quo};
    assign quo_d    = quo;
    assign div_last = (r_cnt == fra_pkg::CNT_W'(MW - 1));

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.num_out = r_num_out;
    assign o_out.den_out = r_den_out;

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output once taken
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd   <= i_in.command;
                        r_na    <= i_in.num_a;
                        r_da    <= i_in.den_a;
                        r_nb    <= i_in.num_b;
                        r_db    <= i_in.den_b;
                        r_cnt   <= '0;
                        r_state <= ST_MUL;
                    end
                end

                // three products, one per cycle
                ST_MUL: begin
                    case (r_cnt[1:0])
                        2'd0:    r_t1 <= prod;
                        2'd1:    r_t2 <= prod;
                        default: r_d  <= prod;
                    endcase
                    if (r_cnt[1:0] == 2'd2) begin
                        r_state <= ST_SUM;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end

                ST_SUM: begin
                    r_n     <= raw_n;
                    r_state <= ST_PREP;
                end

                // zero numerator leaves the raw result
                ST_PREP: begin
                    r_u <= mag_n;
                    r_v <= mag_d;
                    r_k <= '0;
                    if (r_n == '0) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_GCD;
                    end
                end

                // binary gcd, one step per cycle
                ST_GCD: begin
                    if (gcd_done) begin
                        r_g <= gcd_val;
                        if (r_k == '0 && (r_u | r_v) == MW'(1)) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_u     <= mag_n;
                            r_v     <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_DIVN;
                        end
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (!sub_neg) begin
                        r_u <= {1'b0, sub_res[MW-1:1]};
                    end else begin
                        r_u <= {1'b0, sub_flip[MW-1:1]};
                        r_v <= r_u;
                    end
                end

                // restoring division of |n| then |d| by the gcd
                ST_DIVN, ST_DIVD: begin
                    if (!sub_neg) begin
                        r_v <= sub_res[MW-1:0];
                    end else begin
                        r_v <= {r_v[MW-2:0], r_u[MW-1]};
                    end
                    r_u   <= quo;
                    r_cnt <= r_cnt + 1'b1;
                    if (div_last) begin
                        if (r_state == ST_DIVN) begin
                            r_n     <= r_n[fra_pkg::NUM_W-1] ? -quo_n : quo_n;
                            r_u     <= mag_d;
                            r_v     <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_DIVD;
                        end else begin
                            r_d     <= r_d[fra_pkg::DEN_W-1] ? -quo_d : quo_d;
                            r_state <= ST_FIN;
                        end
                    end
                end

                // hold until the output register is free
                ST_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_num_out   <= r_n;
                        r_den_out   <= r_d;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // An accepted transaction drops the input ready in the cycle after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted again right after a transaction");

    // Division runs only with a gcd above one
    a_gcd_above_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVN || r_state == ST_DIVD) |-> (r_g > MW'(1)))
        else $error("division started with gcd of one or zero");

    // Division remainder stays below the divisor
    a_rem_below_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVN || r_state == ST_DIVD) |-> (r_v < r_g))
        else $error("division remainder not below gcd");

    // A zero denominator result carries a numerator of zero or unit magnitude
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.den_out == '0) |->
            (o_out.num_out == 33'sd0 || o_out.num_out == 33'sd1 ||
             o_out.num_out == -33'sd1))
        else $error("zero denominator with unreduced numerator");

endmodule

// ----- sim/fraction_arith_reduce_tb.sv -----
`timescale 1ns / 1ps
// Testbench for fraction_arith_reduce: directed and random fraction operations
// checked against an in-bench gcd predictor. Depends on fra_pkg and fra_if.sv.
module fraction_arith_reduce_tb;

    localparam int  HALF_PERIOD = 2;
    localparam int  RESET_CYCLES = 12;
    localparam int  DRAIN_CYCLES = 200;
    localparam int  MAX_GAP = 8;
    localparam int  HOLD_OFF_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 1_200_000;

    typedef struct {
        logic signed [fra_pkg::NUM_W-1:0] num;
        logic signed [fra_pkg::DEN_W-1:0] den;
    } t_frac_res;

    logic i_clk;
    logic i_rst_n;

    fra_in_if  op_if ();
    fra_out_if res_if ();

    fraction_arith_reduce dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_if),
        .o_out   (res_if)
    );

    t_frac_res reduced_q[$];
    int        err_count = 0;
    longint    cycle_count = 0;
    bit        gaps_on = 1'b0;
    int        stall_left = 0;
    int        hold_cycles = 0;

    // Free-running clock
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Raw result of the operation, divided by the gcd of the magnitudes unless the numerator is zero
    function automatic t_frac_res reduce_fraction(fra_pkg::t_cmd cmd,
                                                   logic signed [fra_pkg::IN_W-1:0] na,
                                                   logic signed [fra_pkg::IN_W-1:0] da,
                                                   logic signed [fra_pkg::IN_W-1:0] nb,
                                                   logic signed [fra_pkg::IN_W-1:0] db);
        longint          n;
        longint          d;
        longint unsigned x;
        longint unsigned y;
        longint unsigned r;
        t_frac_res       res;
        case (cmd)
            fra_pkg::CMD_ADD: begin
                n = longint'(na) * longint'(db) + longint'(nb) * longint'(da);
                d = longint'(da) * longint'(db);
            end
            fra_pkg::CMD_SUB: begin
                n = longint'(na) * longint'(db) - longint'(nb) * longint'(da);
                d = longint'(da) * longint'(db);
            end
            fra_pkg::CMD_MUL: begin
                n = longint'(na) * longint'(nb);
                d = longint'(da) * longint'(db);
            end
            default: begin
                n = longint'(na) * longint'(db);
                d = longint'(da) * longint'(nb);
            end
        endcase
        // Leave a zero numerator unreduced
        if (n != 0) begin
            x = (n < 0) ? longint'(-n) : n;
            y = (d < 0) ? longint'(-d) : d;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            if (x > 1) begin
                n = n / longint'(x);
                d = d / longint'(x);
            end
        end
        res.num = n[fra_pkg::NUM_W-1:0];
        res.den = d[fra_pkg::DEN_W-1:0];
        return res;
    endfunction

    // Offer one transaction; record its expected result on acceptance
    task automatic send_op(fra_pkg::t_cmd cmd, logic signed [fra_pkg::IN_W-1:0] na,
                           logic signed [fra_pkg::IN_W-1:0] da,
                           logic signed [fra_pkg::IN_W-1:0] nb,
                           logic signed [fra_pkg::IN_W-1:0] db);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            op_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        op_if.command = cmd;
        op_if.num_a   = na;
        op_if.den_a   = da;
        op_if.num_b   = nb;
        op_if.den_b   = db;
        op_if.valid   = 1'b1;
        do @(posedge i_clk); while (!op_if.ready);
        reduced_q.push_back(reduce_fraction(cmd, na, da, nb, db));
    endtask

    // Drop valid after the last transaction of a phase
    task automatic release_input();
        @(negedge i_clk);
        op_if.valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (reduced_q.size() != 0) @(posedge i_clk);
    endtask

    // Full-range, small and multiple-of-12 values, so reduction is common, plus edges
    function automatic logic signed [fra_pkg::IN_W-1:0] pick_value();
        logic signed [fra_pkg::IN_W-1:0] edges[9] = '{16'sd0, 16'sd1, -16'sd1, 16'sd2,
                                                      -16'sd2, 16'sd32767, -16'sd32768,
                                                      -16'sd32767, 16'sd16384};
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 3)
            return 16'($urandom_range(0, 16'hFFFF));
        else if (sel <= 6)
            return 16'($signed($urandom_range(0, 40)) - 20);
        else if (sel == 7)
            return edges[$urandom_range(0, 8)];
        else
            return 16'(($signed($urandom_range(0, 30)) - 15) * 12);
    endfunction

    task automatic send_random(int count);
        for (int k = 0; k < count; k++) begin
            send_op(fra_pkg::t_cmd'($urandom_range(0, 3)), pick_value(), pick_value(),
                    pick_value(), pick_value());
        end
    endtask

    // Operations, field extremes, zero numerator, zero denominator, unit gcd
    task automatic test_directed_cases();
        gaps_on = 1'b0;
        send_op(fra_pkg::CMD_ADD, 1, 2, 1, 3);
        send_op(fra_pkg::CMD_SUB, 1, 2, 1, 2);
        send_op(fra_pkg::CMD_MUL, 2, 4, 3, 9);
        send_op(fra_pkg::CMD_DIV, 1, 2, 3, 4);
        send_op(fra_pkg::CMD_ADD, -32768, -32768, -32768, -32768);
        send_op(fra_pkg::CMD_ADD, -32768, 1, -32768, 1);
        send_op(fra_pkg::CMD_MUL, -32768, 1, -32768, 1);
        send_op(fra_pkg::CMD_SUB, 32767, -32768, -32768, 32767);
        send_op(fra_pkg::CMD_MUL, 32767, 32767, 32767, 32767);
        send_op(fra_pkg::CMD_ADD, 5, 0, 3, 7);
        send_op(fra_pkg::CMD_MUL, 5, 3, 7, 0);
        send_op(fra_pkg::CMD_DIV, 5, 3, 0, 7);
        send_op(fra_pkg::CMD_ADD, 0, 0, 0, 0);
        send_op(fra_pkg::CMD_MUL, 0, 5, 9, 3);
        send_op(fra_pkg::CMD_MUL, 1, 1, 1, 1);
        send_op(fra_pkg::CMD_DIV, -1, 1, 1, -1);
        send_op(fra_pkg::CMD_ADD, 1, -1, -1, 1);
        send_op(fra_pkg::CMD_DIV, -32768, 32767, -32768, 32767);
        send_op(fra_pkg::CMD_SUB, 32767, 1, -32768, 1);
        send_op(fra_pkg::CMD_DIV, 0, -32768, 0, -32768);
        send_op(fra_pkg::CMD_DIV, 6, -4, -9, 2);
        release_input();
        wait_drain();
    endtask

    task automatic test_random_gaps(int count);
        gaps_on = 1'b1;
        send_random(count);
        release_input();
        wait_drain();
    endtask

    task automatic test_random_no_gaps(int count);
        gaps_on = 1'b0;
        send_random(count);
        release_input();
        wait_drain();
    endtask

    // Hold the output off while the input keeps offering, so the block fills
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_cycles = HOLD_OFF_CYCLES;
        send_random(12);
        release_input();
        wait_drain();
    endtask

    // Drive the output ready: long hold-off first, then per-result stalls
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready = 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_frac_res exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (reduced_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result num=%0d den=%0d", $realtime,
                         res_if.num_out, res_if.den_out);
            end else begin
                exp_res = reduced_q.pop_front();
                if (res_if.num_out !== exp_res.num) begin
                    err_count++;
                    $display("%0t: num_out expected %0d actual %0d", $realtime,
                             exp_res.num, res_if.num_out);
                end
                if (res_if.den_out !== exp_res.den) begin
                    err_count++;
                    $display("%0t: den_out expected %0d actual %0d", $realtime,
                             exp_res.den, res_if.den_out);
                end
            end
            stall_left = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        op_if.valid   = 1'b0;
        op_if.command = fra_pkg::CMD_ADD;
        op_if.num_a   = '0;
        op_if.den_a   = '0;
        op_if.num_b   = '0;
        op_if.den_b   = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_gaps(1000);
        test_random_no_gaps(400);
        test_output_backpressure();
        test_random_gaps(240);

        // Let any stray output show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && reduced_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
